/* sv/spq_pkg.sv */
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEFAULT = 4;

   localparam int FIELD_W    = 32;
   localparam int ENTRY_W    = 2 * FIELD_W;
   localparam int OCCUPY_W   = 3;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_CMP,
      S_ENQ_PUT,
      S_DEQ_HEAD,
      S_DEQ_MOV,
      S_DONE,
      S_FULL,
      S_EMPTY
   } ctrl_state_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_COUNT,
      POS_ONE,
      POS_INC,
      POS_DEC
   } pos_op_type;

   typedef enum logic {
      WR_SHIFT,
      WR_NEW
   } wr_src_type;

   typedef enum logic {
      ADDR_POS,
      ADDR_POS_M2
   } wr_dst_type;

   typedef struct packed {
      logic           load_req;
      pos_op_type     pos_op;
      logic           wr_en;
      wr_src_type     wr_src;
      wr_dst_type     wr_dst;
      logic           latch_head;
      logic           finish;
      rsp_status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic rank_less;
      logic pos_is_one;
      logic pos_eq_count;
      logic rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

/* sv/spq_ram.sv */
`default_nettype none

module spq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/spq_ctrl.sv */
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_opcode,
   output logic             req_stall,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_ENQ) begin
                  if (stat.count_full) begin
                     state_in = S_FULL;
                  end else if (stat.count_zero) begin
                     state_in = S_ENQ_PUT;
                  end else begin
                     state_in = S_ENQ_CMP;
                  end
               end else begin
                  state_in = stat.count_zero ? S_EMPTY : S_DEQ_HEAD;
               end
            end
         end
         S_ENQ_CMP: begin
            if (stat.rank_less) begin
               state_in = stat.pos_is_one ? S_ENQ_PUT : S_ENQ_CMP;
            end else begin
               state_in = S_ENQ_PUT;
            end
         end
         S_ENQ_PUT:  state_in = S_DONE;
         S_DEQ_HEAD: state_in = stat.pos_eq_count ? S_DONE : S_DEQ_MOV;
         S_DEQ_MOV:  state_in = stat.pos_eq_count ? S_DONE : S_DEQ_MOV;
         S_DONE, S_FULL, S_EMPTY: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.pos_op     = POS_HOLD;
      cmd.wr_src     = WR_SHIFT;
      cmd.wr_dst     = ADDR_POS;
      cmd.code       = ST_DONE;
      req_stall      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
            cmd.pos_op   = (req_opcode == OP_ENQ) ? POS_COUNT : POS_ONE;
         end
         S_ENQ_CMP: begin
            if (stat.rank_less) begin
               cmd.wr_en  = 1'b1;
               cmd.pos_op = POS_DEC;
            end
         end
         S_ENQ_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_NEW;
         end
         S_DEQ_HEAD: begin
            cmd.latch_head = 1'b1;
            cmd.pos_op     = POS_INC;
         end
         S_DEQ_MOV: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_dst = ADDR_POS_M2;
            cmd.pos_op = POS_INC;
         end
         S_DONE: begin
            cmd.finish = stat.rsp_free;
         end
         S_FULL: begin
            cmd.finish = stat.rsp_free;
            cmd.code   = ST_FULL;
         end
         S_EMPTY: begin
            cmd.finish = stat.rsp_free;
            cmd.code   = ST_EMPTY;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/spq_dp.sv */
`default_nettype none

module spq_dp
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   output dp_stat_type                    stat,
   input  wire logic                      req_opcode,
   input  wire logic signed [FIELD_W-1:0] req_item_value,
   input  wire logic signed [FIELD_W-1:0] req_item_rank,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic signed [FIELD_W-1:0]      rsp_head_value,
   output logic signed [FIELD_W-1:0]      rsp_head_rank,
   output logic [OCCUPY_W-1:0]            rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      pos_m1, pos_m2;
   logic               op_ff;
   logic [FIELD_W-1:0] val_ff, rank_ff;
   logic [FIELD_W-1:0] head_val_ff, head_rank_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_status_type     rsp_status_ff;
   logic [FIELD_W-1:0] rsp_val_ff, rsp_rank_ff;
   logic [OCCUPY_W-1:0] rsp_occ_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   always_comb begin
      unique case (cmd.pos_op)
         POS_HOLD:  pos_in = pos_ff;
         POS_COUNT: pos_in = count_ff;
         POS_ONE:   pos_in = CW'(1);
         POS_INC:   pos_in = pos_ff + CW'(1);
         POS_DEC:   pos_in = pos_ff - CW'(1);
         default:   pos_in = pos_ff;
      endcase
   end

   // read runs one step ahead: next cycle sees entry[pos_ff - 1]
   assign pos_m1  = pos_in - CW'(1);
   assign pos_m2  = pos_ff - CW'(2);
   assign rd_addr = pos_m1[AW-1:0];
   assign wr_addr = (cmd.wr_dst == ADDR_POS_M2) ? pos_m2[AW-1:0] : pos_ff[AW-1:0];
   assign wr_data = (cmd.wr_src == WR_NEW) ? {rank_ff, val_ff} : rd_data;
   assign wr_en   = cmd.wr_en;

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.finish && cmd.code == ST_DONE) begin
         count_in = (op_ff == OP_ENQ) ? count_ff + CW'(1) : count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load_req) begin
         op_ff        <= req_opcode;
         val_ff       <= req_item_value;
         rank_ff      <= req_item_rank;
         head_val_ff  <= '0;
         head_rank_ff <= '0;
      end else if (cmd.latch_head) begin
         head_val_ff  <= rd_data[FIELD_W-1:0];
         head_rank_ff <= rd_data[ENTRY_W-1:FIELD_W];
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.code;
         rsp_val_ff    <= head_val_ff;
         rsp_rank_ff   <= head_rank_ff;
         rsp_occ_ff    <= OCCUPY_W'(count_in);
      end
   end

   assign stat.count_zero   = (count_ff == '0);
   assign stat.count_full   = (count_ff == CW'(DEPTH));
   assign stat.rank_less    = ($signed(rank_ff) < $signed(rd_data[ENTRY_W-1:FIELD_W]));
   assign stat.pos_is_one   = (pos_ff == CW'(1));
   assign stat.pos_eq_count = (pos_ff == count_ff);
   assign stat.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_value = rsp_val_ff;
   assign rsp_head_rank  = rsp_rank_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

`default_nettype wire

/* sv/sorted_priority_queue_unit.sv */
// Priority queue of up to DEPTH (value, rank) entries kept sorted by ascending signed
// rank in a single-port-write, registered-read RAM; equal ranks keep arrival order.
// opcode 0 inserts, 1 removes the head. Each transaction gives one response with
// status, the removed entry (zero unless a dequeue succeeded) and the new count.
// One transaction is in flight at a time. An enqueue walks back from the tail,
// comparing ranks: each entry that ranks after the new one is moved back one
// place, and the walk ends at the first entry that does not, or at the head; an
// empty queue takes no compare. A dequeue latches the head and then moves each
// remaining entry forward one place. The walk over the RAM moves one entry per
// cycle. A finished response sits in an output register, so a stalled
// response does not block the accept of the next request.
`default_nettype none

module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_opcode,
   input  wire logic signed [FIELD_W-1:0] req_item_value,
   input  wire logic signed [FIELD_W-1:0] req_item_rank,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic signed [FIELD_W-1:0]      rsp_head_value,
   output logic signed [FIELD_W-1:0]      rsp_head_rank,
   output logic [OCCUPY_W-1:0]            rsp_occupancy
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_item_value (req_item_value),
      .req_item_rank  (req_item_rank),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_head_value (rsp_head_value),
      .rsp_head_rank  (rsp_head_rank),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule

`default_nettype wire

/* sv/spq_checker.sv */
`default_nettype none

module spq_checker
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [1:0]                rsp_status,
   input wire logic signed [FIELD_W-1:0] rsp_head_value,
   input wire logic signed [FIELD_W-1:0] rsp_head_rank,
   input wire logic [OCCUPY_W-1:0]       rsp_occupancy
);

   localparam logic [OCCUPY_W-1:0] FULL_OCC = OCCUPY_W'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_head_value) && $stable(rsp_head_rank) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_head_value == '0 && rsp_head_rank == '0)
      else $error("rejected transaction carries data");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == FULL_OCC)
      else $error("full reject with wrong occupancy");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
      else $error("empty reject with nonzero occupancy");

endmodule

bind sorted_priority_queue_unit spq_checker #(
   .DEPTH (DEPTH)
) u_spq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_head_value (rsp_head_value),
   .rsp_head_rank  (rsp_head_rank),
   .rsp_occupancy  (rsp_occupancy)
);

`default_nettype wire
